[src/assert_macros.svh]
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define TCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset-qualified
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/tcw_pkg.sv]
// shared constants, types and codes for the text console writer
package tcw_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int CELL_AW      = $clog2(CELLS);
  localparam int LAST_CELL    = CELLS - 1;
  localparam int COPY_CELLS   = CELLS - COLUMNS;
  localparam int LAST_ROW_POS = (ROWS - 1) * COLUMNS;

  localparam logic [15:0] BLANK_CELL   = 16'h0F00;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  ATTR_RESET   = 8'h0F;

  localparam logic [1:0] MODE_CHAR  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic {
    SWEEP_IDLE,
    SWEEP_RUN
  } sweep_state_t;

  typedef struct packed {
    logic               active;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [15:0]        wr_data;
  } sweep_req_t;

endpackage

[src/text_console_writer.sv]
// text console writer top level: cursor logic and screen store access
//
// A transaction is accepted on a rising edge with start high and busy low, and
// its result appears with done high for exactly one cycle, the cycle right
// after acceptance; the receiver cannot stall it. Writing a character, a
// newline that stays on screen, reading a cell and the unused mode leave
// busy low, so such transactions may follow back to back. A scroll (a
// character or newline that leaves the last row) and a clear screen start a
// pass over the single-write-port screen store that keeps busy high until it
// is done; the same pass runs after reset before the first transaction is
// taken. The attribute register may be written at any idle time and
// applies to characters accepted afterwards.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        attr_we,
  input  logic [7:0]  text_attribute,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] read_address,
  output logic        done,
  output logic [10:0] cursor_position,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [15:0] read_data
);

  sweep_req_t         sweep;
  logic [7:0]         attr;
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [CELL_AW-1:0] pos, pos_next;
  logic               pend, pend_read;
  logic               accept;
  logic               is_nl, line_break;
  logic               char_we, read_ok;
  logic               sweep_start, sweep_copy;
  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata, mem_rdata;

  assign busy   = sweep.active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (attr_we) begin
      attr <= text_attribute;
    end
  end

  always_comb begin
    col_next    = col;
    row_next    = row;
    pos_next    = pos;
    char_we     = 1'b0;
    sweep_start = 1'b0;
    sweep_copy  = 1'b0;
    is_nl       = (char_code == NEWLINE_CODE);
    line_break  = is_nl || (col == COL_W'(COLUMNS - 1));
    read_ok     = (mode == MODE_READ) && (int'(read_address) < CELLS);
    if (accept) begin
      priority if (mode == MODE_CHAR) begin
        char_we = !is_nl;
        if (line_break) begin
          col_next = '0;
          if (row == ROW_W'(ROWS - 1)) begin
            pos_next    = CELL_AW'(LAST_ROW_POS);
            sweep_start = 1'b1;
            sweep_copy  = 1'b1;
          end else begin
            row_next = row + 1'b1;
            pos_next = pos + CELL_AW'(COLUMNS) - CELL_AW'(col);
          end
        end else begin
          col_next = col + 1'b1;
          pos_next = pos + 1'b1;
        end
      end else if (mode == MODE_CLEAR) begin
        col_next    = '0;
        row_next    = '0;
        pos_next    = '0;
        sweep_start = 1'b1;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      pos       <= '0;
      pend      <= 1'b0;
      pend_read <= 1'b0;
    end else begin
      col       <= col_next;
      row       <= row_next;
      pos       <= pos_next;
      pend      <= accept;
      pend_read <= accept && read_ok;
    end
  end

  always_comb begin
    if (sweep.wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = sweep.wr_addr;
      mem_wdata = sweep.wr_data;
    end else begin
      mem_we    = char_we;
      mem_waddr = pos;
      mem_wdata = {attr, char_code};
    end
    if (sweep.rd_en) begin
      mem_re    = 1'b1;
      mem_raddr = sweep.rd_addr;
    end else begin
      mem_re    = accept && read_ok;
      mem_raddr = CELL_AW'(read_address);
    end
  end

  tcw_screen_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (sweep_start),
    .copy_in (sweep_copy),
    .rdata   (mem_rdata),
    .req     (sweep)
  );

  assign done            = pend;
  assign cursor_position = 11'(pos);
  assign cursor_column   = 7'(col);
  assign cursor_row      = 5'(row);
  assign read_data       = pend_read ? mem_rdata : 16'h0000;

endmodule

[src/tcw_screen_mem.sv]
// screen store: one write port, one registered read port
module tcw_screen_mem
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [CELL_AW-1:0] waddr,
  input  logic [15:0]        wdata,
  input  logic               re,
  input  logic [CELL_AW-1:0] raddr,
  output logic [15:0]        rdata
);

  logic [15:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/tcw_sweep.sv]
// sequencer for full-screen passes: blank fill and scroll-up copy
module tcw_sweep
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        copy_in,
  input  logic [15:0] rdata,
  output sweep_req_t  req
);

  sweep_state_t       state, state_next;
  logic [CELL_AW-1:0] idx, idx_next;
  logic               copy, copy_next;
  logic               wr_pend, wr_pend_next;
  logic [CELL_AW-1:0] wr_addr;
  logic               wr_from_read;
  logic               src_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SWEEP_RUN;
      idx     <= '0;
      copy    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      copy    <= copy_next;
      wr_pend <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr      <= idx;
    wr_from_read <= src_ok;
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    copy_next    = copy;
    wr_pend_next = 1'b0;
    src_ok       = copy && (idx < CELL_AW'(COPY_CELLS));
    req.rd_en    = 1'b0;
    req.rd_addr  = idx + CELL_AW'(COLUMNS);
    unique case (state)
      SWEEP_IDLE: begin
        if (start) begin
          state_next = SWEEP_RUN;
          idx_next   = '0;
          copy_next  = copy_in;
        end
      end
      SWEEP_RUN: begin
        req.rd_en    = src_ok;
        wr_pend_next = 1'b1;
        if (idx == CELL_AW'(LAST_CELL)) begin
          state_next = SWEEP_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
    endcase
    req.wr_en   = wr_pend;
    req.wr_addr = wr_addr;
    req.wr_data = wr_from_read ? rdata : BLANK_CELL;
    req.active  = (state == SWEEP_RUN) || wr_pend;
  end

endmodule

[src/tcw_checker.sv]
// port-level checker for the text console writer, bound to the top level
`include "assert_macros.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode,
  input logic        done,
  input logic [10:0] cursor_position,
  input logic [6:0]  cursor_column,
  input logic [4:0]  cursor_row,
  input logic [15:0] read_data
);

  // every transaction gets its result in the following cycle
  `TCW_ASSERT_NEXT(a_accept_done, start && !busy, done)

  // no result without a transaction
  `TCW_ASSERT_NOW(a_done_source, done, $past(start) && !$past(busy))

  // linear position agrees with row and column
  `TCW_ASSERT_NOW(a_pos_consistent, done,
    cursor_position == 11'(int'(cursor_row) * COLUMNS + int'(cursor_column)))

  // only reads return cell data
  `TCW_ASSERT_NOW(a_data_zero, done && ($past(mode) != MODE_READ), read_data == 16'h0000)

  // clear screen homes the cursor
  `TCW_ASSERT_NOW(a_clear_home, done && ($past(mode) == MODE_CLEAR), cursor_position == 11'd0)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

[tb/sv/text_console_checker.sv]
// checker for the text console writer: predicts each result and compares it
`timescale 1ns / 100ps

module text_console_checker
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        attr_we,
  input  logic [7:0]  text_attribute,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] read_address,
  input  logic        done,
  input  logic [10:0] cursor_position,
  input  logic [6:0]  cursor_column,
  input  logic [4:0]  cursor_row,
  input  logic [15:0] read_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic [10:0] position;
    logic [6:0]  column;
    logic [4:0]  row;
    logic [15:0] data;
  } cursor_report_t;

  logic [15:0]    screen [CELLS];
  int unsigned    col;
  int unsigned    row;
  logic [7:0]     attr;
  cursor_report_t reports_due [$];

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
    col = 0;
    row = ROWS - 1;
  endfunction

  function automatic void line_feed();
    col = 0;
    row++;
    if (row >= ROWS) scroll_screen();
  endfunction

  function automatic cursor_report_t console_step(logic [1:0] m, logic [7:0] c,
                                                  logic [10:0] a);
    cursor_report_t r;
    int unsigned    p;
    r.data = '0;
    case (m)
      MODE_CHAR: begin
        if (c == NEWLINE_CODE) begin
          line_feed();
        end else begin
          screen[col + COLUMNS * row] = {attr, c};
          col++;
          if (col >= COLUMNS) line_feed();
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        col = 0;
        row = 0;
      end
      MODE_READ: begin
        if (a < CELLS) r.data = screen[a];
      end
      default: ;
    endcase
    p = row * COLUMNS + col;
    r.position = p[10:0];
    r.column   = col[6:0];
    r.row      = row[4:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      blank_screen();
      col = 0;
      row = 0;
      attr = ATTR_RESET;
      reports_due.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (done) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result with no transaction pending, actual position %0d data %0d",
                   $time, cursor_position, read_data);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("cursor_position", want.position, cursor_position);
          check_field("cursor_column", want.column, cursor_column);
          check_field("cursor_row", want.row, cursor_row);
          check_field("read_data", want.data, read_data);
          checked++;
        end
      end
      if (start && !busy) reports_due.push_back(console_step(mode, char_code, read_address));
      if (attr_we) attr = text_attribute;
    end
    pending <= reports_due.size();
  end

endmodule

[tb/sv/text_console_writer_test.sv]
// testbench top for the text console writer: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int CYCLE_LIMIT = 8_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        attr_we = 1'b0;
  logic [7:0]  text_attribute = 8'h00;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_CHAR;
  logic [7:0]  char_code = 8'h00;
  logic [10:0] read_address = 11'd0;
  logic        done;
  logic [10:0] cursor_position;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [15:0] read_data;
  int          fail_count;
  int          pending;
  int          checked;

  int cycles = 0;
  int n_char = 0;
  int n_newline = 0;
  int n_clear = 0;
  int n_read = 0;
  int n_unused = 0;

  text_console_writer uut (.*);

  text_console_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] c, input logic [10:0] a);
    start <= 1'b1;
    mode <= m;
    char_code <= c;
    read_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (m)
      MODE_CHAR: begin
        if (c == NEWLINE_CODE) n_newline++;
        else n_char++;
      end
      MODE_CLEAR: n_clear++;
      MODE_READ: n_read++;
      default: n_unused++;
    endcase
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_attribute(input logic [7:0] v);
    attr_we <= 1'b1;
    text_attribute <= v;
    @(posedge clk);
    attr_we <= 1'b0;
  endtask

  task automatic pick_item(output logic [1:0] m, output logic [7:0] c, output logic [10:0] a);
    int r;
    int k;
    r = $urandom_range(999);
    c = 8'($urandom_range(255));
    a = 11'($urandom_range(2047));
    if (r < 30) begin
      m = MODE_UNUSED;
    end else if (r < 34) begin
      m = MODE_CLEAR;
    end else if (r < 230) begin
      m = MODE_READ;
      k = $urandom_range(99);
      if (k < 85) a = 11'($urandom_range(LAST_CELL));
      else if (k < 92) a = 11'($urandom_range(LAST_CELL, LAST_ROW_POS));
      else a = 11'($urandom_range(2047, CELLS));
    end else begin
      m = MODE_CHAR;
      if ($urandom_range(99) < 15) c = NEWLINE_CODE;
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic [7:0]  c;
    logic [10:0] a;
    logic [7:0]  attr_value;
    int          idle_pct;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_quiet();

    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'hFF, 11'(LAST_CELL));
    send_item(MODE_READ, 8'h00, 11'(CELLS));
    send_item(MODE_READ, 8'hFF, 11'h7FF);
    send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_item(MODE_CHAR, 8'h00, 11'h7FF);
    send_item(MODE_CHAR, 8'hFF, 11'd0);
    send_item(MODE_CHAR, 8'h41, 11'd0);
    send_item(MODE_CHAR, NEWLINE_CODE, 11'd0);
    send_item(MODE_CHAR, 8'h7E, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_READ, 8'h00, 11'd2);
    send_item(MODE_READ, 8'h00, 11'(COLUMNS));
    send_item(MODE_UNUSED, 8'h00, 11'd0);
    send_item(MODE_CLEAR, 8'hFF, 11'h7FF);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'(COLUMNS));
    start <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin attr_value = 8'h00; idle_pct = 0; end
        1: begin attr_value = 8'hFF; idle_pct = 78; end
        2: begin attr_value = 8'($urandom_range(254, 1)); idle_pct = 7; end
        3: begin attr_value = ATTR_RESET; idle_pct = 78; end
        4: begin attr_value = 8'($urandom_range(255)); idle_pct = 0; end
        default: begin attr_value = 8'h80; idle_pct = 7; end
      endcase
      wait_quiet();
      set_attribute(attr_value);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        pick_item(m, c, a);
        send_item(m, c, a);
      end
      start <= 1'b0;
    end

    wait_quiet();
    repeat (8) @(posedge clk);

    $display("run covered %0d characters, %0d newlines, %0d clears, %0d reads, %0d unused",
             n_char, n_newline, n_clear, n_read, n_unused);
    $display("%0d results compared over %0d attribute settings in %0d cycles",
             checked, PHASES, cycles);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
